FILE: sv/pvsh_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pvsh_pkg
// Shared types and constants for the pose velocity block with spike hold:
// microcode word layout, sequencer status and register indexes.
// ----------------------------------------------------------------------------
package pvsh_pkg;

    localparam int AXES = 3;

    localparam logic               REG_PEAK_THRESHOLD = 1'b0;
    localparam logic               REG_HEIGHT_OFFSET  = 1'b1;

    localparam logic signed [20:0] USEC_PER_S = 21'sd1000000;
    localparam logic [4:0]         QUO_MSB    = 5'd30;
    localparam logic [1:0]         AXIS_LAST  = 2'd2;

    localparam logic [1:0]         PHASE_EMPTY   = 2'd0;
    localparam logic [1:0]         PHASE_ONE     = 2'd1;
    localparam logic [1:0]         PHASE_RUNNING = 2'd2;

    localparam logic [31:0]        SAT_MAX = 32'h7FFF_FFFF;
    localparam logic [31:0]        SAT_MIN = 32'h8000_0000;

    typedef logic [3:0] step_t;

    typedef enum logic [3:0] {
        OP_NONE   = 4'd0,
        OP_LATCH  = 4'd1,
        OP_DIFF   = 4'd2,
        OP_MUL    = 4'd3,
        OP_PREP   = 4'd4,
        OP_DIV    = 4'd5,
        OP_FRESH  = 4'd6,
        OP_SPIKE  = 4'd7,
        OP_COMMIT = 4'd8,
        OP_FIRST  = 4'd9,
        OP_ZERO   = 4'd10
    } ctl_op_t;

    typedef enum logic [2:0] {
        C_NEXT     = 3'd0,
        C_WAIT_IN  = 3'd1,
        C_PHASE0   = 3'd2,
        C_DT_ZERO  = 3'd3,
        C_DIV_MORE = 3'd4,
        C_AXIS_MORE = 3'd5,
        C_OUT_WAIT = 3'd6
    } ctl_cond_t;

    typedef struct packed {
        ctl_op_t   op;
        ctl_cond_t cond;
        step_t     target;
    } ucode_word_t;

    typedef struct packed {
        logic in_fire;
        logic phase0;
        logic dt_zero;
        logic div_more;
        logic axis_more;
        logic out_busy;
    } seq_status_t;

endpackage

FILE: sv/pvsh_ucode.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pvsh_ucode
// Step counter and control store: one control word per step, with
// conditional jumps on datapath status.
// ----------------------------------------------------------------------------
module pvsh_ucode
    import pvsh_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  seq_status_t status,
    output ucode_word_t ctl
);

    localparam step_t STEP_WAIT   = 4'd0;
    localparam step_t STEP_CHK0   = 4'd1;
    localparam step_t STEP_CHK1   = 4'd2;
    localparam step_t STEP_DIFF   = 4'd3;
    localparam step_t STEP_MUL    = 4'd4;
    localparam step_t STEP_PREP   = 4'd5;
    localparam step_t STEP_DIV    = 4'd6;
    localparam step_t STEP_FRESH  = 4'd7;
    localparam step_t STEP_SPIKE  = 4'd8;
    localparam step_t STEP_COMMIT = 4'd9;
    localparam step_t STEP_FIRST  = 4'd10;
    localparam step_t STEP_ZERO   = 4'd11;

    step_t pc_reg;
    step_t pc_next;
    step_t pc_inc;

    function automatic ucode_word_t rom(input step_t pc);
        ucode_word_t w;
        case (pc)
            STEP_WAIT:   w = '{OP_LATCH,  C_WAIT_IN,   STEP_WAIT};
            STEP_CHK0:   w = '{OP_NONE,   C_PHASE0,    STEP_FIRST};
            STEP_CHK1:   w = '{OP_NONE,   C_DT_ZERO,   STEP_ZERO};
            STEP_DIFF:   w = '{OP_DIFF,   C_NEXT,      STEP_WAIT};
            STEP_MUL:    w = '{OP_MUL,    C_NEXT,      STEP_WAIT};
            STEP_PREP:   w = '{OP_PREP,   C_NEXT,      STEP_WAIT};
            STEP_DIV:    w = '{OP_DIV,    C_DIV_MORE,  STEP_DIV};
            STEP_FRESH:  w = '{OP_FRESH,  C_AXIS_MORE, STEP_DIFF};
            STEP_SPIKE:  w = '{OP_SPIKE,  C_NEXT,      STEP_WAIT};
            STEP_COMMIT: w = '{OP_COMMIT, C_OUT_WAIT,  STEP_WAIT};
            STEP_FIRST:  w = '{OP_FIRST,  C_OUT_WAIT,  STEP_WAIT};
            STEP_ZERO:   w = '{OP_ZERO,   C_OUT_WAIT,  STEP_WAIT};
            default:     w = '{OP_NONE,   C_OUT_WAIT,  STEP_WAIT};
        endcase
        return w;
    endfunction

    assign ctl    = rom(pc_reg);
    assign pc_inc = pc_reg + 4'd1;

    always_comb
    begin
        case (ctl.cond)
            C_NEXT:      pc_next = pc_inc;
            C_WAIT_IN:   pc_next = status.in_fire   ? pc_inc     : pc_reg;
            C_PHASE0:    pc_next = status.phase0    ? ctl.target : pc_inc;
            C_DT_ZERO:   pc_next = status.dt_zero   ? ctl.target : pc_inc;
            C_DIV_MORE:  pc_next = status.div_more  ? ctl.target : pc_inc;
            C_AXIS_MORE: pc_next = status.axis_more ? ctl.target : pc_inc;
            C_OUT_WAIT:  pc_next = status.out_busy  ? pc_reg     : ctl.target;
            default:     pc_next = STEP_WAIT;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg <= STEP_WAIT;
        end
        else
        begin
            pc_reg <= pc_next;
        end
    end

endmodule

FILE: sv/pvsh_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pvsh_datapath
// Working registers, shared multiplier, serial divider, spike compare and
// output register, driven by the control word of the current step.
// ----------------------------------------------------------------------------
module pvsh_datapath
    import pvsh_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  ucode_word_t   ctl,
    output seq_status_t   status,
    input  logic          cfg_we,
    input  logic          cfg_index,
    input  logic [31:0]   cfg_data,
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    input  logic [127:0]  s_axis_tdata,
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    output logic [191:0]  m_axis_tdata,
    output logic [0:0]    m_axis_tuser
);

    logic [30:0]        thr_reg;
    logic signed [31:0] hoff_reg;
    logic [1:0]         phase_reg;
    logic [31:0]        last_stamp_reg;
    logic signed [31:0] last_pos_reg  [AXES];
    logic signed [31:0] last_diff_reg [AXES];
    logic signed [31:0] held_reg      [AXES];
    logic signed [31:0] fresh_reg     [AXES];

    logic [31:0]        stamp_in_reg;
    logic signed [31:0] pos_in_reg [AXES];
    logic [31:0]        dt_reg;
    logic [1:0]         axis_reg;
    logic signed [32:0] d_reg;
    logic signed [52:0] prod_reg;
    logic [30:0]        mag_reg;
    logic               neg_reg;
    logic               cap_reg;
    logic [31:0]        rem_reg;
    logic [30:0]        quo_reg;
    logic [4:0]         cnt_reg;
    logic               spike_reg;

    logic               out_valid_reg;
    logic [191:0]       out_data_reg;
    logic               out_spike_reg;

    logic               in_fire;
    logic               out_busy;
    logic               commit_en;
    logic signed [52:0] prod_full;
    logic [51:0]        mag_full;
    logic [30:0]        low_bits;
    logic [32:0]        trial;
    logic               trial_ge;
    logic [31:0]        trial_sub;
    logic [31:0]        q_pos;
    logic [31:0]        q_val;
    logic [32:0]        zdiff;
    logic [31:0]        cal_z;
    logic               over [AXES];
    logic signed [31:0] vel_out [AXES];

    assign s_axis_tready = (ctl.op == OP_LATCH);
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign out_busy      = out_valid_reg && !m_axis_tready;
    assign commit_en     = ((ctl.op == OP_COMMIT) || (ctl.op == OP_FIRST)
                            || (ctl.op == OP_ZERO)) && !out_busy;

    assign status.in_fire   = in_fire;
    assign status.phase0    = (phase_reg == PHASE_EMPTY);
    assign status.dt_zero   = (dt_reg == 32'd0);
    assign status.div_more  = (cnt_reg != 5'd0);
    assign status.axis_more = (axis_reg != AXIS_LAST);
    assign status.out_busy  = out_busy;

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_spike_reg;

    assign prod_full = d_reg * USEC_PER_S;
    assign mag_full  = prod_reg[52] ? 52'(-prod_reg) : prod_reg[51:0];
    assign low_bits  = mag_reg;
    assign trial     = {rem_reg, low_bits[cnt_reg]};
    assign trial_ge  = (trial >= {1'b0, dt_reg});
    assign trial_sub = trial[31:0] - dt_reg;

    assign q_pos = {1'b0, quo_reg};

    always_comb
    begin
        if (neg_reg)
        begin
            q_val = cap_reg ? SAT_MIN : 32'(-q_pos);
        end
        else
        begin
            q_val = cap_reg ? SAT_MAX : q_pos;
        end
    end

    assign zdiff = {pos_in_reg[2][31], pos_in_reg[2]} - {hoff_reg[31], hoff_reg};

    always_comb
    begin
        if (zdiff[32] != zdiff[31])
        begin
            cal_z = zdiff[32] ? SAT_MIN : SAT_MAX;
        end
        else
        begin
            cal_z = zdiff[31:0];
        end
    end

    always_comb
    begin
        logic signed [31:0] base;
        logic [32:0]        jump;
        logic [32:0]        jump_abs;
        for (int i = 0; i < AXES; i++)
        begin
            base     = (phase_reg == PHASE_ONE) ? fresh_reg[i] : last_diff_reg[i];
            jump     = {fresh_reg[i][31], fresh_reg[i]} - {base[31], base};
            jump_abs = jump[32] ? 33'(-jump) : jump;
            over[i]  = (jump_abs > {2'b00, thr_reg});
            case (ctl.op)
                OP_FIRST: vel_out[i] = 32'sd0;
                OP_ZERO:  vel_out[i] = held_reg[i];
                default:  vel_out[i] = spike_reg ? held_reg[i] : fresh_reg[i];
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg        <= SAT_MAX[30:0];
            hoff_reg       <= 32'sd0;
            phase_reg      <= PHASE_EMPTY;
            last_stamp_reg <= 32'd0;
            out_valid_reg  <= 1'b0;
            for (int i = 0; i < AXES; i++)
            begin
                last_pos_reg[i]  <= 32'sd0;
                last_diff_reg[i] <= 32'sd0;
                held_reg[i]      <= 32'sd0;
            end
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_PEAK_THRESHOLD: thr_reg  <= cfg_data[30:0];
                    REG_HEIGHT_OFFSET:  hoff_reg <= cfg_data;
                    default:            ;
                endcase
            end

            if (commit_en)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end

            if (commit_en)
            begin
                last_stamp_reg <= stamp_in_reg;
                for (int i = 0; i < AXES; i++)
                begin
                    last_pos_reg[i] <= pos_in_reg[i];
                end
                case (ctl.op)
                    OP_FIRST:
                    begin
                        phase_reg <= PHASE_ONE;
                        for (int i = 0; i < AXES; i++)
                        begin
                            last_diff_reg[i] <= 32'sd0;
                        end
                    end
                    OP_COMMIT:
                    begin
                        if (phase_reg == PHASE_ONE)
                        begin
                            phase_reg <= PHASE_RUNNING;
                        end
                        for (int i = 0; i < AXES; i++)
                        begin
                            last_diff_reg[i] <= fresh_reg[i];
                            if (!spike_reg)
                            begin
                                held_reg[i] <= fresh_reg[i];
                            end
                        end
                    end
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            stamp_in_reg  <= s_axis_tdata[31:0];
            pos_in_reg[0] <= s_axis_tdata[63:32];
            pos_in_reg[1] <= s_axis_tdata[95:64];
            pos_in_reg[2] <= s_axis_tdata[127:96];
            dt_reg        <= s_axis_tdata[31:0] - last_stamp_reg;
            axis_reg      <= 2'd0;
        end

        case (ctl.op)
            OP_DIFF:
            begin
                d_reg <= {pos_in_reg[axis_reg][31], pos_in_reg[axis_reg]}
                         - {last_pos_reg[axis_reg][31], last_pos_reg[axis_reg]};
            end
            OP_MUL:
            begin
                prod_reg <= prod_full;
            end
            OP_PREP:
            begin
                neg_reg <= prod_reg[52];
                mag_reg <= mag_full[30:0];
                cap_reg <= ({11'd0, mag_full[51:31]} >= dt_reg);
                rem_reg <= {11'd0, mag_full[51:31]};
                quo_reg <= 31'd0;
                cnt_reg <= QUO_MSB;
            end
            OP_DIV:
            begin
                rem_reg <= trial_ge ? trial_sub : trial[31:0];
                quo_reg <= {quo_reg[29:0], trial_ge};
                cnt_reg <= cnt_reg - 5'd1;
            end
            OP_FRESH:
            begin
                fresh_reg[axis_reg] <= q_val;
                axis_reg            <= axis_reg + 2'd1;
            end
            OP_SPIKE:
            begin
                spike_reg <= over[0] || over[1] || over[2];
            end
            default: ;
        endcase

        if (commit_en)
        begin
            out_data_reg  <= {vel_out[2], vel_out[1], vel_out[0],
                              cal_z, pos_in_reg[1], pos_in_reg[0]};
            out_spike_reg <= (ctl.op == OP_ZERO) || ((ctl.op == OP_COMMIT) && spike_reg);
        end
    end

endmodule

FILE: sv/pose_velocity_spike_hold.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pose_velocity_spike_hold
// Calibrated position and finite-difference velocity with a hold on
// velocity spikes; a microcoded sequencer drives a shared datapath.
//
//   channel  dir  width  content
//   s_axis   in   128    beat: stamp_us, pos_x, pos_y, pos_z
//   m_axis   out  192+1  beat: cal_x..vel_z, tuser spike_held
//   cfg      in   1+32   write: register index, data
//
// A running beat goes from accept to the next ready through two check steps,
// three axes of difference, multiply, prepare, 31 serial divide steps and a
// saturating finish each, the spike check and output write. The first beat
// after reset goes from the first check to the output write, a beat with zero
// time step from the second. The output register holds a result while the
// next beat is taken; a final step stalls only while that register is full.
// Reset clears all history, the threshold to its maximum and the offset.
// ----------------------------------------------------------------------------
module pose_velocity_spike_hold
    import pvsh_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_we,
    input  logic         cfg_index,
    input  logic [31:0]  cfg_data,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [127:0] s_axis_tdata,   // stamp_us, pos_x, pos_y, pos_z
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [191:0] m_axis_tdata,   // cal_x, cal_y, cal_z, vel_x, vel_y, vel_z
    output logic [0:0]   m_axis_tuser    // spike_held
);

    ucode_word_t ctl;
    seq_status_t status;

    pvsh_ucode u_ucode (
        .clk    (clk),
        .rst_n  (rst_n),
        .status (status),
        .ctl    (ctl)
    );

    pvsh_datapath u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .ctl           (ctl),
        .status        (status),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

endmodule

FILE: sim/pose_velocity_spike_hold_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pose_velocity_spike_hold_test
// Self-checking bench for the pose velocity block with spike hold. A queue of
// pose samples feeds a stream driver. Each accepted beat runs through an
// in-bench velocity predictor that keeps its own history, threshold and
// height offset. A stream monitor compares each result beat with the oldest
// prediction.
//
// The stimulus has three parts:
//   - directed samples for the first sample, a zero time step, seeding,
//     counter wrap and saturation, with the extremes of both registers;
//   - six random rounds of smooth tracks with noise, jumps and repeated
//     stamps mixed in;
//   - a register setting per round, and sender gaps and receiver stalls
//     that change from round to round.
// ----------------------------------------------------------------------------
module pose_velocity_spike_hold_test;
    import pvsh_pkg::*;

    localparam int     RANDOM_SAMPLES    = 1140;
    localparam int     RANDOM_ROUNDS     = 6;
    localparam int     CYCLE_LIMIT       = 1_000_000;
    localparam int     TAIL_CYCLES       = 120;
    localparam int     REPORT_LIMIT      = 10;
    localparam longint MICROS_PER_SECOND = 1_000_000;
    localparam longint INT32_HI          = 64'sd2147483647;
    localparam longint INT32_LO          = -64'sd2147483648;

    typedef struct packed {
        logic signed [31:0] pos_z;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_x;
        logic [31:0]        stamp_us;
    } pose_sample_t;

    typedef struct packed {
        logic               spike_held;
        logic signed [31:0] vel_z;
        logic signed [31:0] vel_y;
        logic signed [31:0] vel_x;
        logic signed [31:0] cal_z;
        logic signed [31:0] cal_y;
        logic signed [31:0] cal_x;
    } pose_result_t;

    logic         clk           = 1'b0;
    logic         rst_n         = 1'b0;
    logic         cfg_we        = 1'b0;
    logic         cfg_index     = 1'b0;
    logic [31:0]  cfg_data      = '0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [127:0] s_axis_tdata  = '0;  // stamp_us, pos_x, pos_y, pos_z
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [191:0] m_axis_tdata;        // cal_x, cal_y, cal_z, vel_x, vel_y, vel_z
    logic [0:0]   m_axis_tuser;        // spike_held

    pose_sample_t sample_queue [$];
    pose_result_t result_due [$];

    int unsigned send_gap_pct   = 9;
    int unsigned recv_stall_pct = 59;
    int unsigned cycles         = 0;
    int unsigned samples_sent   = 0;
    int unsigned results_seen   = 0;
    int unsigned holds_seen     = 0;
    int unsigned reg_writes     = 0;
    int unsigned mismatches     = 0;

    logic [30:0]        peak_limit = '1;
    logic signed [31:0] z_offset   = '0;
    logic [1:0]         seen_phase = PHASE_EMPTY;
    logic [31:0]        prev_stamp = '0;
    longint             coord_hist [3] = '{0, 0, 0};
    longint             prev_rate  [3] = '{0, 0, 0};
    longint             held_rate  [3] = '{0, 0, 0};

    pose_velocity_spike_hold dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #2 clk = ~clk;

    function automatic longint clamp32(input longint v);
        if (v > INT32_HI)
            return INT32_HI;
        if (v < INT32_LO)
            return INT32_LO;
        return v;
    endfunction

    function automatic pose_result_t advance_pose(input pose_sample_t s);
        pose_result_t r;
        longint       p     [3];
        longint       fresh [3];
        longint       rate  [3];
        longint       jump;
        logic [31:0]  dt;
        logic         spike;
        p[0]  = s.pos_x;
        p[1]  = s.pos_y;
        p[2]  = s.pos_z;
        spike = 1'b0;
        fresh = '{0, 0, 0};
        rate  = '{0, 0, 0};
        if (seen_phase == PHASE_EMPTY)
        begin
            prev_rate  = '{0, 0, 0};
            seen_phase = PHASE_ONE;
        end
        else
        begin
            dt = s.stamp_us - prev_stamp;
            if (dt == '0)
                spike = 1'b1;
            else
            begin
                for (int i = 0; i < 3; i++)
                    fresh[i] = clamp32((p[i] - coord_hist[i]) * MICROS_PER_SECOND
                                       / longint'({32'b0, dt}));
                // seed the previous rate so the second sample never trips
                if (seen_phase == PHASE_ONE)
                begin
                    prev_rate  = fresh;
                    seen_phase = PHASE_RUNNING;
                end
                for (int i = 0; i < 3; i++)
                begin
                    jump = fresh[i] - prev_rate[i];
                    if (jump < 0)
                        jump = -jump;
                    if (jump > longint'({33'b0, peak_limit}))
                        spike = 1'b1;
                end
                for (int i = 0; i < 3; i++)
                begin
                    if (!spike)
                        held_rate[i] = fresh[i];
                    prev_rate[i] = fresh[i];
                end
            end
            for (int i = 0; i < 3; i++)
                rate[i] = spike ? held_rate[i] : fresh[i];
        end
        coord_hist   = p;
        prev_stamp   = s.stamp_us;
        r.cal_x      = s.pos_x;
        r.cal_y      = s.pos_y;
        r.cal_z      = 32'(clamp32(p[2] - longint'(z_offset)));
        r.vel_x      = 32'(rate[0]);
        r.vel_y      = 32'(rate[1]);
        r.vel_z      = 32'(rate[2]);
        r.spike_held = spike;
        return r;
    endfunction

    function automatic void queue_sample(input logic [31:0] stamp, px, py, pz);
        sample_queue.push_back('{pos_z: pz, pos_y: py, pos_x: px, stamp_us: stamp});
    endfunction

    task automatic write_reg(input logic idx, input logic [31:0] value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == REG_PEAK_THRESHOLD)
            peak_limit = value[30:0];
        else
            z_offset = value;
        reg_writes++;
    endtask

    // hold until every queued sample is taken and every result is back
    task automatic wait_idle();
        while (sample_queue.size() != 0 || s_axis_tvalid || result_due.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
        end
        else if (!s_axis_tvalid || s_axis_tready)
        begin
            if (s_axis_tvalid)
            begin
                result_due.push_back(advance_pose(s_axis_tdata));
                samples_sent++;
            end
            if (sample_queue.size() != 0 && $urandom_range(99) >= send_gap_pct)
            begin
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= sample_queue.pop_front();
            end
            else
                s_axis_tvalid <= 1'b0;
        end
    end

    always @(posedge clk or negedge rst_n)
    begin : monitor
        pose_result_t got;
        pose_result_t want;
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                got = {m_axis_tuser, m_axis_tdata};
                results_seen++;
                if (got.spike_held)
                    holds_seen++;
                if (result_due.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT)
                        $display("result beat %0d with nothing expected: %h",
                                 results_seen, got);
                end
                else
                begin
                    want = result_due.pop_front();
                    if (got.cal_x !== want.cal_x || got.cal_y !== want.cal_y
                        || got.cal_z !== want.cal_z || got.vel_x !== want.vel_x
                        || got.vel_y !== want.vel_y || got.vel_z !== want.vel_z
                        || got.spike_held !== want.spike_held)
                    begin
                        mismatches++;
                        if (mismatches <= REPORT_LIMIT)
                            $display({"result beat %0d: expected cal %h %h %h vel %h %h %h",
                                      " held %b, got cal %h %h %h vel %h %h %h held %b"},
                                     results_seen, want.cal_x, want.cal_y, want.cal_z,
                                     want.vel_x, want.vel_y, want.vel_z, want.spike_held,
                                     got.cal_x, got.cal_y, got.cal_z,
                                     got.vel_x, got.vel_y, got.vel_z, got.spike_held);
                    end
                end
            end
            m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("no progress within %0d cycles", CYCLE_LIMIT);
            $display("tb: failure");
            $finish;
        end
    end

    initial
    begin : stimulus
        int          round;
        int          n;
        int          pick;
        int          jit;
        int          base_dt;
        int          step [3];
        logic [31:0] track [4];
        logic [31:0] thr_value;
        logic [31:0] ofs_value;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // default registers: first sample, repeated stamp before seeding, seeding
        // with saturated rates, counter wrap
        queue_sample(32'd1000, 32'd0, 32'd0, 32'd0);
        queue_sample(32'd1000, 32'd5, 32'd5, 32'd5);
        queue_sample(32'd1001, 32'h7FFF_FFFF, 32'h8000_0000, 32'd0);
        queue_sample(32'd1000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        queue_sample(32'd0, 32'd0, 32'd0, 32'h8000_0000);
        queue_sample(32'hFFFF_FFFF, 32'd1, -32'sd1, 32'd0);
        queue_sample(32'd0, 32'd2, -32'sd2, 32'd0);
        queue_sample(32'd1_000_000, 32'd65536, -32'sd65536, 32'd32768);
        queue_sample(32'd2_000_000, 32'd131072, -32'sd131072, 32'd65536);
        wait_idle();

        // zero threshold (bit 31 set and dropped), lowest offset
        write_reg(REG_PEAK_THRESHOLD, 32'h8000_0000);
        write_reg(REG_HEIGHT_OFFSET, 32'h8000_0000);
        queue_sample(32'd3_000_000, 32'd196608, -32'sd196608, 32'd98304);
        queue_sample(32'd4_000_000, 32'd262144, -32'sd262144, 32'd131072);
        queue_sample(32'd5_000_000, 32'd327681, -32'sd327680, 32'd163840);
        queue_sample(32'd5_000_000, 32'd400000, -32'sd400000, 32'd200000);
        queue_sample(32'd6_000_000, 32'd400000, -32'sd400000, 32'h7FFF_FFFF);
        wait_idle();

        // widest threshold, highest offset
        write_reg(REG_PEAK_THRESHOLD, 32'hFFFF_FFFF);
        write_reg(REG_HEIGHT_OFFSET, 32'h7FFF_FFFF);
        queue_sample(32'd6_000_100, 32'd400100, -32'sd400100, 32'h8000_0000);
        queue_sample(32'd6_000_200, 32'd400200, -32'sd400200, 32'd0);
        queue_sample(32'd6_000_201, 32'h8000_0000, 32'h7FFF_FFFF, -32'sd1);
        wait_idle();

        for (round = 0; round < RANDOM_ROUNDS; round++)
        begin
            send_gap_pct   = (round < 2) ? 9 : (round < 4) ? 59 : 0;
            recv_stall_pct = (round < 2) ? 59 : (round < 4) ? 9 : 0;
            case (round)
                0:       thr_value = $urandom;
                2:       thr_value = '0;
                3:       thr_value = 32'h7FFF_FFFF;
                default: thr_value = 32'd1 << $urandom_range(14, 26);
            endcase
            case (round)
                1:       ofs_value = 32'h8000_0000;
                2:       ofs_value = 32'h7FFF_FFFF;
                4:       ofs_value = '0;
                default: ofs_value = $urandom;
            endcase
            write_reg(REG_PEAK_THRESHOLD, thr_value);
            write_reg(REG_HEIGHT_OFFSET, ofs_value);
            for (int a = 0; a < 4; a++)
                track[a] = $urandom;
            base_dt = 1000;
            step    = '{0, 0, 0};
            jit     = 16;
            for (n = 0; n < RANDOM_SAMPLES / RANDOM_ROUNDS; n++)
            begin
                // new smooth segment: rate, time step and jitter
                if (n % 40 == 0)
                begin
                    base_dt = ($urandom_range(99) < 80) ? $urandom_range(100, 5000)
                                                        : $urandom_range(1, 20);
                    for (int a = 0; a < 3; a++)
                        step[a] = int'($urandom_range(0, 8192)) - 4096;
                    jit = 1 << $urandom_range(0, 8);
                end
                pick = $urandom_range(99);
                if (pick < 10)
                begin
                    for (int a = 0; a < 4; a++)
                        track[a] = $urandom;
                end
                else if (pick < 14)
                begin
                    for (int a = 1; a < 4; a++)
                        track[a] = track[a] + int'($urandom_range(0, 2 * jit)) - jit;
                end
                else if (pick < 18)
                begin
                    track[0] = track[0] + base_dt;
                    track[$urandom_range(1, 3)] = $urandom;
                end
                else
                begin
                    track[0] = track[0] + base_dt + $urandom_range(0, 2);
                    for (int a = 1; a < 4; a++)
                        track[a] = track[a] + step[a - 1]
                                   + int'($urandom_range(0, 2 * jit)) - jit;
                end
                queue_sample(track[0], track[1], track[2], track[3]);
            end
            wait_idle();
        end

        repeat (TAIL_CYCLES) @(posedge clk);
        $display("covered %0d pose samples and %0d result beats, %0d of them held after a spike",
                 samples_sent, results_seen, holds_seen);
        $display("ran %0d register writes over %0d threshold and offset settings",
                 reg_writes, RANDOM_ROUNDS + 3);
        if (mismatches == 0)
            $display("tb: success");
        else
        begin
            $display("%0d result beats mismatched", mismatches);
            $display("tb: failure");
        end
        $finish;
    end

endmodule
